[design/assert_macros.svh]
// Assertion helpers shared by the RTL. Every check is clocked on clk and
// is switched off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons must hold as well.
`define AST_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication: whenever ante holds, cons must hold in the following cycle.
`define AST_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[design/mf3_pkg.sv]
`timescale 1ns / 1ps
package mf3_pkg;

  // Fixed field widths
  localparam int PIX_W    = 8;
  localparam int ROW_W    = 12;
  localparam int COL_W    = 10;
  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 13;

  // Register reset values and clamp floor
  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 11'd512;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 13'd512;
  localparam int MIN_SIZE = 3;

  // Register indexes (byte address bit 2)
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // Window and sorter
  localparam int WIN_N       = 9;
  localparam int SORT_ROUNDS = 9;
  localparam int MEDIAN_IDX  = 4;

  // Result queue
  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // Result selector codes within one step
  localparam logic [1:0] SEL_A = 2'd0;  // pixel one row up, one column left
  localparam logic [1:0] SEL_B = 2'd1;  // right border pixel one row up
  localparam logic [1:0] SEL_C = 2'd2;  // last-row pixel itself

  // Everything one accepted item needs to produce its results
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [COL_W-1:0] wlast;
    logic [PIX_W-1:0] center;
    logic [PIX_W-1:0] up;
    logic [PIX_W-1:0] px;
    logic             interior;
    logic             a_ok;
    logic             b_ok;
    logic             c_ok;
    logic             fe;
  } step_t;

endpackage

[design/mf3_cx_cell.sv]
`timescale 1ns / 1ps
// Compare-exchange cell: registers the smaller input on lo_r, the larger on hi_r.
module mf3_cx_cell (
  input  logic                     clk,
  input  logic [mf3_pkg::PIX_W-1:0] a,
  input  logic [mf3_pkg::PIX_W-1:0] b,
  output logic [mf3_pkg::PIX_W-1:0] lo_r,
  output logic [mf3_pkg::PIX_W-1:0] hi_r
);

  // Order the pair
  always_ff @(posedge clk) begin
    if (a > b) begin
      lo_r <= b;
      hi_r <= a;
    end else begin
      lo_r <= a;
      hi_r <= b;
    end
  end

endmodule

[design/mf3_line_buf.sv]
`timescale 1ns / 1ps
// Two line stores: the row above and the row two above the current one.
module mf3_line_buf #(
  parameter int DEPTH = 1024
) (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [$clog2(DEPTH)-1:0]  rd_addr,
  input  logic                      wr_en,
  input  logic [$clog2(DEPTH)-1:0]  wr_addr,
  input  logic [mf3_pkg::PIX_W-1:0] wr_px,
  output logic [mf3_pkg::PIX_W-1:0] up_r,
  output logic [mf3_pkg::PIX_W-1:0] up2_r
);

  logic [mf3_pkg::PIX_W-1:0] above_mem [DEPTH];
  logic [mf3_pkg::PIX_W-1:0] two_above_mem [DEPTH];

  // Read both rows for the incoming column
  always_ff @(posedge clk) begin
    if (rd_en) begin
      up_r  <= above_mem[rd_addr];
      up2_r <= two_above_mem[rd_addr];
    end
  end

  // Push the column down: new pixel into the row above, old one below it
  always_ff @(posedge clk) begin
    if (wr_en) begin
      above_mem[wr_addr]     <= wr_px;
      two_above_mem[wr_addr] <= up_r;
    end
  end

endmodule

[design/mf3_out_fifo.sv]
`timescale 1ns / 1ps
// Queue of finished steps waiting for the result channel.
module mf3_out_fifo (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  mf3_pkg::step_t            push_data,
  input  logic                      pop,
  output mf3_pkg::step_t            head,
  output logic [mf3_pkg::CNT_W-1:0] cnt
);

  mf3_pkg::step_t                   mem_r [mf3_pkg::FIFO_DEPTH];
  logic [mf3_pkg::FIFO_AW-1:0]      wr_ptr_r;
  logic [mf3_pkg::FIFO_AW-1:0]      rd_ptr_r;
  logic [mf3_pkg::CNT_W-1:0]        cnt_r;
  logic [mf3_pkg::CNT_W-1:0]        cnt_nxt;

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Track fill level
  always_comb begin
    cnt_nxt = cnt_r + mf3_pkg::CNT_W'(push) - mf3_pkg::CNT_W'(pop);
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + mf3_pkg::FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + mf3_pkg::FIFO_AW'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  assign head = mem_r[rd_ptr_r];
  assign cnt  = cnt_r;

endmodule

[design/median_3x3_filter.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Channel  | Direction | Handshake           | Payload
// ---------+-----------+---------------------+--------------------------------------
// in       | input     | in_valid / in_stall | in_pixel_in
// out      | output    | out_valid/out_stall | out_row, out_col, out_pixel_out,
//          |           |                     | out_frame_end
// cfg      | input     | APB psel/penable    | image_width @0x0, image_height @0x4
//
// An item's first result is offered after the line-store read at acceptance, nine
// compare-exchange rounds and the queue write. One item per cycle while results keep pace.
// A step with two or three results holds the result channel until each has left, so on the
// last row input slows once the queue backs up.
// in_stall rises once 16 items are in flight or queued; out_stall only fills that queue.
// Synchronous rst_n clears counters, window and queue, sets both sizes to 512, not lines.
module median_3x3_filter #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  // pixel input
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [mf3_pkg::PIX_W-1:0]   in_pixel_in,
  // filtered output
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [mf3_pkg::ROW_W-1:0]   out_row,
  output logic [mf3_pkg::COL_W-1:0]   out_col,
  output logic [mf3_pkg::PIX_W-1:0]   out_pixel_out,
  output logic                        out_frame_end
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  logic [mf3_pkg::WIDTH_W-1:0]  width_r;
  logic [mf3_pkg::HEIGHT_W-1:0] height_r;
  logic                         cfg_wr;

  logic [CW-1:0] wm1;
  logic [RW-1:0] hm1;
  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;
  logic          last_col;
  logic          last_row;
  logic          in_acc;

  logic           s0_v_r;
  logic [CW-1:0]  s0_col_r;
  mf3_pkg::step_t s0_meta_r;
  mf3_pkg::step_t s0_meta_nxt;
  mf3_pkg::step_t meta0;

  logic [mf3_pkg::PIX_W-1:0] line_up;
  logic [mf3_pkg::PIX_W-1:0] line_up2;
  logic [mf3_pkg::PIX_W-1:0] win_r   [mf3_pkg::WIN_N];
  logic [mf3_pkg::PIX_W-1:0] win_nxt [mf3_pkg::WIN_N];

  wire  [mf3_pkg::PIX_W-1:0] stg [0:mf3_pkg::SORT_ROUNDS][0:mf3_pkg::WIN_N-1];

  mf3_pkg::step_t                 meta_r [mf3_pkg::SORT_ROUNDS];
  logic [mf3_pkg::SORT_ROUNDS-1:0] mv_r;
  mf3_pkg::step_t                 tail;
  logic                           tail_v;
  logic                           has_res;
  mf3_pkg::step_t                 push_ent;
  logic                           fifo_push;
  logic                           drop;

  mf3_pkg::step_t             head;
  logic [mf3_pkg::CNT_W-1:0]  fifo_cnt;
  logic [mf3_pkg::CNT_W-1:0]  occ_r;
  logic [mf3_pkg::CNT_W-1:0]  occ_nxt;
  logic [2:0]                 done_r;
  logic [2:0]                 done_nxt;
  logic [2:0]                 pend;
  logic [2:0]                 sel_oh;
  logic [1:0]                 sel_code;
  logic                       out_acc;
  logic                       pop;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= mf3_pkg::WIDTH_RST;
      height_r <= mf3_pkg::HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        mf3_pkg::REG_WIDTH:  width_r  <= pwdata[mf3_pkg::WIDTH_W-1:0];
        mf3_pkg::REG_HEIGHT: height_r <= pwdata[mf3_pkg::HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      mf3_pkg::REG_WIDTH:  prdata = 32'(width_r);
      mf3_pkg::REG_HEIGHT: prdata = 32'(height_r);
      default:             prdata = '0;
    endcase
  end

  // Clamp the sizes and keep them as last index
  always_comb begin
    if (int'(width_r) < mf3_pkg::MIN_SIZE) begin
      wm1 = CW'(mf3_pkg::MIN_SIZE - 1);
    end else if (int'(width_r) > MAX_WIDTH) begin
      wm1 = CW'(MAX_WIDTH - 1);
    end else begin
      wm1 = CW'(width_r - mf3_pkg::WIDTH_W'(1));
    end
    if (int'(height_r) < mf3_pkg::MIN_SIZE) begin
      hm1 = RW'(mf3_pkg::MIN_SIZE - 1);
    end else if (int'(height_r) > MAX_HEIGHT) begin
      hm1 = RW'(MAX_HEIGHT - 1);
    end else begin
      hm1 = RW'(height_r - mf3_pkg::HEIGHT_W'(1));
    end
  end

  // ---------------------------------------------------------------- input
  assign in_acc   = in_valid & ~in_stall;
  assign last_col = col_r >= wm1;
  assign last_row = row_r >= hm1;

  // Advance the raster position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      if (last_col) begin
        col_r <= '0;
        row_r <= last_row ? '0 : row_r + RW'(1);
      end else begin
        col_r <= col_r + CW'(1);
      end
    end
  end

  // Decide which results this item will produce
  always_comb begin
    s0_meta_nxt          = '0;
    s0_meta_nxt.row      = mf3_pkg::ROW_W'(row_r);
    s0_meta_nxt.col      = mf3_pkg::COL_W'(col_r);
    s0_meta_nxt.wlast    = mf3_pkg::COL_W'(wm1);
    s0_meta_nxt.px       = in_pixel_in;
    s0_meta_nxt.interior = (row_r >= RW'(2)) && (col_r >= CW'(2)) && (col_r <= wm1);
    s0_meta_nxt.a_ok     = (row_r != '0) && (col_r != '0);
    s0_meta_nxt.b_ok     = (row_r != '0) && last_col;
    s0_meta_nxt.c_ok     = last_row;
    s0_meta_nxt.fe       = last_col;
  end

  // Hold the item while the line stores are read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else begin
      s0_v_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s0_meta_r <= s0_meta_nxt;
      s0_col_r  <= col_r;
    end
  end

  mf3_line_buf #(
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (col_r),
    .wr_en   (s0_v_r),
    .wr_addr (s0_col_r),
    .wr_px   (s0_meta_r.px),
    .up_r    (line_up),
    .up2_r   (line_up2)
  );

  // ---------------------------------------------------------------- window
  // Shift each row left and load the new column on the right
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_nxt[i*3]     = win_r[i*3+1];
      win_nxt[i*3 + 1] = win_r[i*3+2];
    end
    win_nxt[2] = line_up2;
    win_nxt[5] = line_up;
    win_nxt[8] = s0_meta_r.px;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mf3_pkg::WIN_N; i++) begin
        win_r[i] <= '0;
      end
    end else if (s0_v_r) begin
      win_r <= win_nxt;
    end
  end

  // Center of the shifted window is the old right-middle cell
  always_comb begin
    meta0        = s0_meta_r;
    meta0.center = win_r[5];
    meta0.up     = line_up;
  end

  // ---------------------------------------------------------------- sorter
  // Odd-even transposition: one row of compare-exchange cells per round
  for (genvar gi = 0; gi < mf3_pkg::WIN_N; gi++) begin : g_load
    assign stg[0][gi] = win_nxt[gi];
  end

  for (genvar k = 0; k < mf3_pkg::SORT_ROUNDS; k++) begin : g_round
    localparam int FIRST = k % 2;
    localparam int PASS  = (FIRST == 0) ? mf3_pkg::WIN_N - 1 : 0;
    logic [mf3_pkg::PIX_W-1:0] pass_r;

    for (genvar j = 0; j < (mf3_pkg::WIN_N - 1) / 2; j++) begin : g_cell
      mf3_cx_cell u_cell (
        .clk  (clk),
        .a    (stg[k][FIRST + 2*j]),
        .b    (stg[k][FIRST + 2*j + 1]),
        .lo_r (stg[k+1][FIRST + 2*j]),
        .hi_r (stg[k+1][FIRST + 2*j + 1])
      );
    end

    // Carry the unpaired cell
    always_ff @(posedge clk) begin
      pass_r <= stg[k][PASS];
    end
    assign stg[k+1][PASS] = pass_r;
  end

  // Carry the item description alongside the sorter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r <= '0;
    end else begin
      mv_r <= {mv_r[mf3_pkg::SORT_ROUNDS-2:0], s0_v_r};
    end
  end

  always_ff @(posedge clk) begin
    meta_r[0] <= meta0;
    for (int k = 1; k < mf3_pkg::SORT_ROUNDS; k++) begin
      meta_r[k] <= meta_r[k-1];
    end
  end

  // Pick median or center and queue the step
  assign tail    = meta_r[mf3_pkg::SORT_ROUNDS-1];
  assign tail_v  = mv_r[mf3_pkg::SORT_ROUNDS-1];
  assign has_res = tail.a_ok | tail.b_ok | tail.c_ok;

  always_comb begin
    push_ent = tail;
    if (tail.interior) begin
      push_ent.center = stg[mf3_pkg::SORT_ROUNDS][mf3_pkg::MEDIAN_IDX];
    end
  end

  assign fifo_push = tail_v & has_res;
  assign drop      = tail_v & ~has_res;

  mf3_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fifo_push),
    .push_data (push_ent),
    .pop       (pop),
    .head      (head),
    .cnt       (fifo_cnt)
  );

  // ---------------------------------------------------------------- output
  assign out_valid = fifo_cnt != '0;
  assign out_acc   = out_valid & ~out_stall;
  assign pend      = {head.c_ok, head.b_ok, head.a_ok} & ~done_r;

  // Send results of a step in order A, B, C
  always_comb begin
    if (pend[0]) begin
      sel_code = mf3_pkg::SEL_A;
      sel_oh   = 3'b001;
    end else if (pend[1]) begin
      sel_code = mf3_pkg::SEL_B;
      sel_oh   = 3'b010;
    end else begin
      sel_code = mf3_pkg::SEL_C;
      sel_oh   = 3'b100;
    end
  end

  always_comb begin
    case (sel_code)
      mf3_pkg::SEL_A: begin
        out_row       = head.row - mf3_pkg::ROW_W'(1);
        out_col       = head.col - mf3_pkg::COL_W'(1);
        out_pixel_out = head.center;
        out_frame_end = 1'b0;
      end
      mf3_pkg::SEL_B: begin
        out_row       = head.row - mf3_pkg::ROW_W'(1);
        out_col       = head.wlast;
        out_pixel_out = head.up;
        out_frame_end = 1'b0;
      end
      default: begin
        out_row       = head.row;
        out_col       = head.col;
        out_pixel_out = head.px;
        out_frame_end = head.fe;
      end
    endcase
  end

  // Drop the head once its last pending result leaves
  assign pop = out_acc & ((pend & ~sel_oh) == 3'b000);

  always_comb begin
    done_nxt = done_r;
    if (pop) begin
      done_nxt = '0;
    end else if (out_acc) begin
      done_nxt = done_r | sel_oh;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= '0;
    end else begin
      done_r <= done_nxt;
    end
  end

  // ---------------------------------------------------------------- flow control
  // Count items from acceptance until their last result leaves
  always_comb begin
    occ_nxt = occ_r + mf3_pkg::CNT_W'(in_acc) - mf3_pkg::CNT_W'(drop)
            - mf3_pkg::CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  assign in_stall = occ_r >= mf3_pkg::CNT_W'(mf3_pkg::FIFO_DEPTH);

  // ---------------------------------------------------------------- checks
  `AST_IMP(a_occ_bound, 1'b1, occ_r <= mf3_pkg::CNT_W'(mf3_pkg::FIFO_DEPTH))
  `AST_IMP(a_queue_in_occ, 1'b1, fifo_cnt <= occ_r)
  `AST_IMP(a_head_pending, out_valid, pend != 3'b000)
  `AST_IMP(a_fe_on_last_row, out_valid && out_frame_end, sel_code == mf3_pkg::SEL_C)

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;

  localparam int MAX_W       = 1024;
  localparam int MAX_H       = 4096;
  localparam int SETTLE      = 32;
  localparam int LONG_HOLD   = 300;
  localparam int QUIET_LIMIT = 5000;
  localparam int SEG_ITEMS   = 12;

  localparam logic [mf3_pkg::PIX_W-1:0] CORNER_PX [9] = '{
    8'h00, 8'hFF, 8'h00,
    8'hFF, 8'h80, 8'hFF,
    8'h00, 8'hFF, 8'h01
  };
  localparam logic [mf3_pkg::PIX_W-1:0] STRIPE_PX [15] = '{
    8'hAA, 8'h55, 8'hFF, 8'h00, 8'h7F,
    8'h80, 8'h01, 8'hFE, 8'h10, 8'hEF,
    8'h33, 8'hCC, 8'h0F, 8'hF0, 8'h99
  };

  typedef struct packed {
    logic [mf3_pkg::ROW_W-1:0] row;
    logic [mf3_pkg::COL_W-1:0] col;
    logic [mf3_pkg::PIX_W-1:0] pixel;
    logic                      frame_end;
  } filt_px_t;

  // Tracks the window and line stores and holds the filtered pixels still due
  class median_check;
    logic [mf3_pkg::WIDTH_W-1:0]  width_reg;
    logic [mf3_pkg::HEIGHT_W-1:0] height_reg;
    logic [mf3_pkg::PIX_W-1:0]    line_above [MAX_W];
    logic [mf3_pkg::PIX_W-1:0]    line_two_above [MAX_W];
    logic [mf3_pkg::PIX_W-1:0]    win [mf3_pkg::WIN_N];
    int unsigned                  row_cnt;
    int unsigned                  col_cnt;
    filt_px_t                     pending_pixels [$];
    int                           mismatches;

    function new();
      width_reg  = mf3_pkg::WIDTH_RST;
      height_reg = mf3_pkg::HEIGHT_RST;
      foreach (line_above[i]) begin
        line_above[i]     = '0;
        line_two_above[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      row_cnt    = 0;
      col_cnt    = 0;
      mismatches = 0;
    endfunction

    function int unsigned clamp_dim(int unsigned v, int unsigned hi);
      if (v < mf3_pkg::MIN_SIZE) return mf3_pkg::MIN_SIZE;
      if (v > hi) return hi;
      return v;
    endfunction

    function int unsigned cur_width();
      return clamp_dim(32'(width_reg), MAX_W);
    endfunction

    function int unsigned cur_height();
      return clamp_dim(32'(height_reg), MAX_H);
    endfunction

    function int pending();
      return pending_pixels.size();
    endfunction

    function void set_reg(logic idx, logic [31:0] value);
      if (idx == mf3_pkg::REG_WIDTH) width_reg = value[mf3_pkg::WIDTH_W-1:0];
      else height_reg = value[mf3_pkg::HEIGHT_W-1:0];
    endfunction

    function logic [mf3_pkg::PIX_W-1:0] window_median();
      logic [mf3_pkg::PIX_W-1:0] s [mf3_pkg::WIN_N];
      logic [mf3_pkg::PIX_W-1:0] v;
      int j;
      foreach (win[i]) s[i] = win[i];
      for (int i = 1; i < mf3_pkg::WIN_N; i++) begin
        v = s[i];
        j = i - 1;
        while (j >= 0 && s[j] > v) begin
          s[j+1] = s[j];
          j--;
        end
        s[j+1] = v;
      end
      return s[mf3_pkg::MEDIAN_IDX];
    endfunction

    function void queue_pixel(int unsigned row, int unsigned col,
                              logic [mf3_pkg::PIX_W-1:0] pix, logic fe);
      filt_px_t e;
      e.row       = row[mf3_pkg::ROW_W-1:0];
      e.col       = col[mf3_pkg::COL_W-1:0];
      e.pixel     = pix;
      e.frame_end = fe;
      pending_pixels.push_back(e);
    endfunction

    // Advance the window by one accepted pixel and queue what it releases
    function void accept_pixel(logic [mf3_pkg::PIX_W-1:0] px);
      int unsigned w, h, r, c;
      logic last_col, last_row, interior;
      logic [mf3_pkg::PIX_W-1:0] up, up2, v;
      w = cur_width();
      h = cur_height();
      r = row_cnt;
      c = col_cnt;
      last_col = (c >= w - 1);
      last_row = (r >= h - 1);
      up  = '0;
      up2 = '0;
      if (c < MAX_W) begin
        up  = line_above[c];
        up2 = line_two_above[c];
        line_two_above[c] = up;
        line_above[c]     = px;
      end
      for (int i = 0; i < 3; i++) begin
        win[i*3]   = win[i*3+1];
        win[i*3+1] = win[i*3+2];
      end
      win[2] = up2;
      win[5] = up;
      win[8] = px;
      if (r >= 1) begin
        if (c >= 1) begin
          interior = (r >= 2) && (c >= 2) && (c <= w - 1);
          v = interior ? window_median() : win[4];
          queue_pixel(r - 1, c - 1, v, 1'b0);
        end
        if (last_col) queue_pixel(r - 1, w - 1, win[5], 1'b0);
      end
      if (last_row) queue_pixel(r, c, px, last_col);
      if (last_col) begin
        col_cnt = 0;
        row_cnt = last_row ? 0 : r + 1;
      end else begin
        col_cnt = c + 1;
      end
    endfunction

    // Compare one output pixel with the oldest one due
    function void check_output(logic [mf3_pkg::ROW_W-1:0] row, logic [mf3_pkg::COL_W-1:0] col,
                               logic [mf3_pkg::PIX_W-1:0] pix, logic fe);
      filt_px_t want;
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output pixel: row %0d col %0d pixel %0d end %0d",
                   row, col, pix, fe);
      end else begin
        want = pending_pixels.pop_front();
        if (row !== want.row || col !== want.col || pix !== want.pixel ||
            fe !== want.frame_end) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"output mismatch: expected row %0d col %0d pixel %0d end %0d,",
                      " got row %0d col %0d pixel %0d end %0d"},
                     want.row, want.col, want.pixel, want.frame_end, row, col, pix, fe);
        end
      end
    endfunction
  endclass

  logic                        clk;
  logic                        rst_n = 1'b0;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [2:0]                  paddr = '0;
  logic [31:0]                 pwdata = '0;
  logic [31:0]                 prdata;
  logic                        pready;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [mf3_pkg::PIX_W-1:0]   in_pixel_in = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [mf3_pkg::ROW_W-1:0]   out_row;
  logic [mf3_pkg::COL_W-1:0]   out_col;
  logic [mf3_pkg::PIX_W-1:0]   out_pixel_out;
  logic                        out_frame_end;

  median_check med_chk;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_reqs = 0;
  int hold_served = 0;
  int hold_left = 0;

  median_3x3_filter uut (
    .clk, .rst_n,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_stall, .in_pixel_in,
    .out_valid, .out_stall, .out_row, .out_col, .out_pixel_out, .out_frame_end
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Take output pixels; stall at random or for a requested long stretch
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall)
        med_chk.check_output(out_row, out_col, out_pixel_out, out_frame_end);
      if (hold_reqs != hold_served) begin
        hold_served <= hold_reqs;
        hold_left   <= LONG_HOLD;
        out_stall   <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // End the run when no item moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("median_3x3_filter regression: fail");
    $finish;
  end

  // Offer one pixel after a random gap and hold it until taken
  task automatic send_pixel(input logic [mf3_pkg::PIX_W-1:0] px);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_pixel_in <= px;
    do @(posedge clk); while (in_stall);
    med_chk.accept_pixel(px);
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) send_pixel(mf3_pkg::PIX_W'($urandom_range(0, 255)));
  endtask

  // Stop offering until every pixel due has come and the pipeline is empty
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (med_chk.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    med_chk.set_reg(idx, value);
  endtask

  task automatic set_size(input int w_raw, input int h_raw);
    wait_drained();
    write_reg(mf3_pkg::REG_WIDTH, w_raw);
    write_reg(mf3_pkg::REG_HEIGHT, h_raw);
  endtask

  initial begin
    int w, h, n, half, frame_no, seg_items;
    med_chk = new();
    send_idle_pct = 8;
    recv_idle_pct = 82;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Smallest frame, sizes below the floor: a single interior pixel
    set_size(0, 0);
    for (int i = 0; i < 9; i++) send_pixel(CORNER_PX[i]);
    // Three interior pixels, all-ones/all-zeros bit patterns
    set_size(5, 2);
    for (int i = 0; i < 15; i++) send_pixel(STRIPE_PX[i]);

    // Widest row, clamped from the top of the register, cut short in the first row
    set_size(2047, 3);
    send_random(20);
    wait_drained();
    write_reg(mf3_pkg::REG_WIDTH, 0);
    send_random(7);

    // Tallest frame, cut short by lowering the height at a row boundary
    set_size(3, 8191);
    send_random(15);
    wait_drained();
    write_reg(mf3_pkg::REG_HEIGHT, 0);
    send_random(3);

    // Random frames in three idling segments
    frame_no = 0;
    for (int seg = 0; seg < 3; seg++) begin
      if (seg == 1) begin
        send_idle_pct = 82;
        recv_idle_pct = 8;
      end else if (seg == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      seg_items = 0;
      while (seg_items < SEG_ITEMS) begin
        if (seg == 2 && seg_items == 0) begin
          // Fill the block behind a long output hold
          set_size(3, 9);
          hold_reqs <= hold_reqs + 1;
        end else if (frame_no == 0 || $urandom_range(0, 2) != 0) begin
          w = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
          h = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 4);
          set_size(w, h);
        end
        n = med_chk.cur_width() * med_chk.cur_height();
        if (frame_no % 4 == 1) begin
          // Pause mid-frame until every pixel due has arrived
          half = n / 2;
          send_random(half);
          wait_drained();
          send_random(n - half);
        end else begin
          send_random(n);
        end
        seg_items += n;
        frame_no++;
      end
    end

    in_valid <= 1'b0;
    while (med_chk.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    med_chk.mismatches += med_chk.pending();
    if (med_chk.mismatches == 0) $display("median_3x3_filter regression: pass");
    else $display("median_3x3_filter regression: fail");
    $finish;
  end

endmodule
